// ----- sv/fsfe_pkg.sv -----
// Shared types and constants of the mount-table format field extractor.
// Used by every module of the block; depends on nothing.

package fsfe_pkg;

    // Result codes carried on the kind port.
    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_NOTFOUND  = 2'd3
    } kind_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NAME_LENGTH = 2'd0;
    localparam logic [1:0] CFG_NAME_LOW    = 2'd1;
    localparam logic [1:0] CFG_NAME_HIGH   = 2'd2;

    localparam int MAX_NAME_BYTES_DEFAULT = 16;
    localparam int POS_W       = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_HASH    = 8'h23;

    // One queue entry holds all results caused by one input beat. When two is
    // set, a second result of kind found follows the first one.
    typedef struct packed {
        logic       two;
        kind_t      kind;
        logic [7:0] data;
    } entry_t;

endpackage

// ----- sv/fsfe_front.sv -----
// Front end: configuration registers, line parser and name compare.
// Turns each accepted text byte into at most one queue entry; uses fsfe_pkg.

module fsfe_front #(
    parameter int MAX_NAME_BYTES = fsfe_pkg::MAX_NAME_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              accept,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    output fsfe_pkg::entry_t  entry,
    output logic              entry_valid
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_DEV,
        PH_GAP1,
        PH_NAME,
        PH_GAP2,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    localparam logic [fsfe_pkg::POS_W-1:0] MAX_POS = fsfe_pkg::POS_W'(MAX_NAME_BYTES);

    logic [fsfe_pkg::POS_W-1:0] name_length_reg;
    logic [63:0]                name_low_reg;
    logic [63:0]                name_high_reg;

    phase_t                     phase_reg, phase_next;
    logic [fsfe_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       match_reg, match_next;

    logic [127:0] name_all;
    assign name_all = {name_high_reg, name_low_reg};

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic name_done(input logic [fsfe_pkg::POS_W-1:0] pos,
                                       input logic m,
                                       input logic [fsfe_pkg::POS_W-1:0] len);
        return m && (len != '0) && (len <= MAX_POS) && (pos == len);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg <= fsfe_pkg::POS_W'(1);
            name_low_reg    <= '0;
            name_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fsfe_pkg::CFG_NAME_LENGTH: name_length_reg <= cfg_data[fsfe_pkg::POS_W-1:0];
                fsfe_pkg::CFG_NAME_LOW:    name_low_reg    <= cfg_data;
                fsfe_pkg::CFG_NAME_HIGH:   name_high_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        logic                       nl;
        logic                       sp;
        logic                       enter;
        logic [fsfe_pkg::POS_W-1:0] pos_e;
        logic                       m_e;
        logic [7:0]                 want;
        logic                       have;
        phase_t                     ph;

        nl    = (text_byte == fsfe_pkg::CHAR_NEWLINE);
        sp    = is_space(text_byte);
        enter = (phase_reg == PH_GAP1) && !sp;
        pos_e = enter ? '0 : pos_reg;
        m_e   = enter ? 1'b1 : match_reg;
        want  = name_all[{pos_e[3:0], 3'b000} +: 8];

        ph          = phase_reg;
        pos_next    = pos_e;
        match_next  = m_e;
        have        = 1'b0;
        entry.two   = 1'b0;
        entry.kind  = fsfe_pkg::KIND_BYTE;
        entry.data  = '0;

        case (phase_reg)
            PH_LEAD:
            begin
                if (!sp)
                begin
                    ph = (text_byte == fsfe_pkg::CHAR_HASH) ? PH_SKIP : PH_DEV;
                end
            end
            PH_DEV:
            begin
                if (nl)
                begin
                    ph = PH_LEAD;
                end
                else if (sp)
                begin
                    ph = PH_GAP1;
                end
            end
            PH_GAP1:
            begin
                if (nl)
                begin
                    ph = PH_LEAD;
                end
                else if (!sp)
                begin
                    ph = PH_NAME;
                end
            end
            PH_GAP2:
            begin
                if (nl)
                begin
                    have       = 1'b1;
                    entry.kind = fsfe_pkg::KIND_MALFORMED;
                    ph         = PH_DONE;
                end
                else if (!sp)
                begin
                    have       = 1'b1;
                    entry.data = text_byte;
                    ph         = PH_FMT;
                end
            end
            PH_FMT:
            begin
                have = 1'b1;
                if (sp)
                begin
                    entry.kind = fsfe_pkg::KIND_FOUND;
                    ph         = PH_DONE;
                end
                else
                begin
                    entry.data = text_byte;
                end
            end
            PH_SKIP:
            begin
                if (nl)
                begin
                    ph = PH_LEAD;
                end
            end
            default:
            begin
            end
        endcase

        // Name compare, also for the first name byte that leaves the gap.
        if ((phase_reg == PH_NAME) || enter)
        begin
            if (sp)
            begin
                if (name_done(pos_e, m_e, name_length_reg))
                begin
                    if (nl)
                    begin
                        have       = 1'b1;
                        entry.kind = fsfe_pkg::KIND_MALFORMED;
                        ph         = PH_DONE;
                    end
                    else
                    begin
                        ph = PH_GAP2;
                    end
                end
                else
                begin
                    ph = nl ? PH_LEAD : PH_SKIP;
                end
            end
            else if (m_e && (pos_e < name_length_reg) && (pos_e < MAX_POS) &&
                     (text_byte == want))
            begin
                pos_next = pos_e + 1'b1;
            end
            else
            begin
                match_next = 1'b0;
            end
        end

        // End of text closes the search and returns to the line start.
        if (end_of_text)
        begin
            if (ph != PH_DONE)
            begin
                if (have)
                begin
                    // Only a format byte can be pending here, so found follows.
                    entry.two = 1'b1;
                end
                else
                begin
                    have = 1'b1;
                    if (ph == PH_FMT)
                    begin
                        entry.kind = fsfe_pkg::KIND_FOUND;
                    end
                    else if ((ph == PH_GAP2) ||
                             ((ph == PH_NAME) &&
                              name_done(pos_next, match_next, name_length_reg)))
                    begin
                        entry.kind = fsfe_pkg::KIND_MALFORMED;
                    end
                    else
                    begin
                        entry.kind = fsfe_pkg::KIND_NOTFOUND;
                    end
                end
            end
            ph         = PH_LEAD;
            pos_next   = '0;
            match_next = 1'b1;
        end

        phase_next  = ph;
        entry_valid = accept && have;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            pos_reg   <= '0;
            match_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
        end
    end

endmodule

// ----- sv/fsfe_queue.sv -----
// Short entry queue between the parser front end and the result back end.
// Holds fsfe_pkg::entry_t items; depth from fsfe_pkg::QUEUE_DEPTH.

module fsfe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  fsfe_pkg::entry_t  wr_entry,
    input  logic              rd_en,
    output fsfe_pkg::entry_t  rd_entry,
    output logic              full,
    output logic              empty
);

    localparam int DEPTH = fsfe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fsfe_pkg::entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- sv/fsfe_back.sv -----
// Back end: unpacks queue entries into result beats, one beat per pop.
// Uses fsfe_pkg types; reads the head of fsfe_queue.

module fsfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  fsfe_pkg::entry_t  head,
    input  logic              head_valid,
    output logic              head_release,
    input  logic              pop,
    output logic [1:0]        kind,
    output logic [7:0]        format_byte,
    output logic              run_last
);

    logic second_reg, second_next;
    logic take;

    assign take        = pop && head_valid;
    assign kind        = second_reg ? fsfe_pkg::KIND_FOUND : head.kind;
    assign format_byte = second_reg ? 8'h00 : head.data;
    assign run_last    = second_reg || !head.two;

    // The entry leaves the queue with its final beat.
    assign head_release = take && run_last;

    always_comb
    begin
        second_next = second_reg;
        if (take)
        begin
            second_next = !second_reg && head.two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
        end
    end

endmodule

// ----- sv/fstab_format_field_extractor.sv -----
// Top level of the mount-table format field extractor.
// Instantiates fsfe_front, fsfe_queue and fsfe_back; uses fsfe_pkg.
//
// Usage: the table text is pushed one byte per beat (text_byte, with
// end_of_text set on the final byte) while full is low. On the first line
// whose second token equals the configured name, the third token comes
// out one result beat per byte (kind byte), then a found beat. A matching
// line with no third token gives malformed; no match by the end of the
// text gives not found. Bytes after an answer give nothing until the end.
// Results are taken with pop while empty is low; run_last marks the last
// result beat caused by one input byte.
// Timing: one input byte per cycle while full is low. A result is written
// into the queue when its byte is accepted. A byte that causes two results
// (the last format byte at the end of the text) needs a pop for each; a
// four-entry queue lets the result side stall without stopping input until
// it fills, at which point full rises. Reset clears the parser to the line
// start, empties the queue and sets the name length to one with all name
// bytes zero. Configuration is written through cfg_we, cfg_index and
// cfg_data while idle.

module fstab_format_field_extractor #(
    parameter int MAX_NAME_BYTES = fsfe_pkg::MAX_NAME_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  format_byte,
    output logic        run_last
);

    fsfe_pkg::entry_t new_entry;
    fsfe_pkg::entry_t head_entry;
    logic             new_valid;
    logic             head_release;
    logic             accept;

    // A byte is taken whenever the queue has room, even if it adds no entry.
    assign accept = push && !full;

    fsfe_front #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .entry       (new_entry),
        .entry_valid (new_valid)
    );

    fsfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (new_valid),
        .wr_entry (new_entry),
        .rd_en    (head_release),
        .rd_entry (head_entry),
        .full     (full),
        .empty    (empty)
    );

    fsfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_entry),
        .head_valid   (!empty),
        .head_release (head_release),
        .pop          (pop),
        .kind         (kind),
        .format_byte  (format_byte),
        .run_last     (run_last)
    );

`ifndef SYNTHESIS
    // The first of two beats from one byte is always a format byte.
    a_pair_starts_with_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !run_last) |-> (kind == fsfe_pkg::KIND_BYTE))
        else $error("first beat of a pair is not a format byte");

    // Only format byte beats carry data.
    a_data_only_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind != fsfe_pkg::KIND_BYTE)) |-> (format_byte == 8'h00))
        else $error("status beat carries a nonzero byte");

    // Every status beat ends the run of its byte.
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind != fsfe_pkg::KIND_BYTE)) |-> run_last)
        else $error("status beat without run_last");

    // After the first beat of a pair is popped, the found beat follows.
    a_pair_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !run_last) |=>
        (!empty && run_last && (kind == fsfe_pkg::KIND_FOUND)))
        else $error("second beat of a pair missing");
`endif

endmodule

// ----- sim/tb_fsfe_pkg.sv -----
// Scoreboard for the mount-table format field extractor testbench: a
// cycle-free predictor of the result beats plus the queue they wait in.
// Depends on fsfe_pkg for the result kinds, register indexes and characters.
`timescale 1ns / 1ps

package tb_fsfe_pkg;
    import fsfe_pkg::*;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_DEVICE,
        SCAN_GAP1,
        SCAN_NAME,
        SCAN_GAP2,
        SCAN_FORMAT,
        SCAN_SKIP,
        SCAN_DONE
    } scan_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } answer_beat_t;

    class format_scoreboard;
        logic [4:0]   want_len;
        logic [127:0] want_name;
        scan_phase_t  phase;
        int           name_pos;
        bit           name_ok;
        answer_beat_t answers_due[$];
        answer_beat_t step_answers[$];
        int           mismatches;
        int           kind_seen[4];

        function new();
            want_len   = 5'd1;
            want_name  = '0;
            mismatches = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
            restart_line();
        endfunction

        function void restart_line();
            phase    = SCAN_LEAD;
            name_pos = 0;
            name_ok  = 1'b1;
        endfunction

        function void write_register(logic [1:0] index, logic [63:0] value);
            case (index)
                CFG_NAME_LENGTH: want_len = value[4:0];
                CFG_NAME_LOW:    want_name[63:0] = value;
                CFG_NAME_HIGH:   want_name[127:64] = value;
                default: ;
            endcase
        endfunction

        function bit name_complete();
            return name_ok && want_len >= 1 && want_len <= MAX_NAME_BYTES_DEFAULT &&
                   name_pos == want_len;
        endfunction

        function void add_answer(kind_t k, logic [7:0] b);
            answer_beat_t a;
            if (step_answers.size() >= 2)
                return;
            a.kind = k;
            a.data = b;
            a.last = 1'b0;
            step_answers.push_back(a);
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        // Advances the line parser by one text byte and queues what it answers.
        function void predict_answer(logic [7:0] c, logic eot);
            bit nl;
            bit sp;
            bit at_name;
            nl      = (c == CHAR_NEWLINE);
            sp      = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
            at_name = 1'b0;
            step_answers.delete();

            case (phase)
                SCAN_LEAD:
                    if (!sp)
                        phase = (c == CHAR_HASH) ? SCAN_SKIP : SCAN_DEVICE;
                SCAN_DEVICE:
                    if (nl)
                        phase = SCAN_LEAD;
                    else if (sp)
                        phase = SCAN_GAP1;
                SCAN_GAP1:
                    if (nl)
                        phase = SCAN_LEAD;
                    else if (!sp)
                    begin
                        // The first name byte is compared right away.
                        name_pos = 0;
                        name_ok  = 1'b1;
                        phase    = SCAN_NAME;
                        at_name  = 1'b1;
                    end
                SCAN_NAME:
                    at_name = 1'b1;
                SCAN_GAP2:
                    if (nl)
                    begin
                        add_answer(KIND_MALFORMED, 8'h00);
                        phase = SCAN_DONE;
                    end
                    else if (!sp)
                    begin
                        add_answer(KIND_BYTE, c);
                        phase = SCAN_FORMAT;
                    end
                SCAN_FORMAT:
                    if (sp)
                    begin
                        add_answer(KIND_FOUND, 8'h00);
                        phase = SCAN_DONE;
                    end
                    else
                        add_answer(KIND_BYTE, c);
                SCAN_SKIP:
                    if (nl)
                        phase = SCAN_LEAD;
                default: ;
            endcase

            if (at_name)
            begin
                if (sp)
                begin
                    if (name_complete())
                    begin
                        if (nl)
                        begin
                            add_answer(KIND_MALFORMED, 8'h00);
                            phase = SCAN_DONE;
                        end
                        else
                            phase = SCAN_GAP2;
                    end
                    else
                        phase = nl ? SCAN_LEAD : SCAN_SKIP;
                end
                else if (name_ok && name_pos < want_len && name_pos < MAX_NAME_BYTES_DEFAULT &&
                         c == want_name[8*name_pos +: 8])
                    name_pos++;
                else
                    name_ok = 1'b0;
            end

            if (eot)
            begin
                if (phase == SCAN_FORMAT)
                    add_answer(KIND_FOUND, 8'h00);
                else if (phase == SCAN_GAP2 || (phase == SCAN_NAME && name_complete()))
                    add_answer(KIND_MALFORMED, 8'h00);
                else if (phase != SCAN_DONE)
                    add_answer(KIND_NOTFOUND, 8'h00);
                restart_line();
            end

            if (step_answers.size() > 0)
                step_answers[step_answers.size() - 1].last = 1'b1;
            foreach (step_answers[i])
                answers_due.push_back(step_answers[i]);
        endfunction

        function void check_answer(logic [1:0] k, logic [7:0] b, logic l);
            answer_beat_t e;
            if (answers_due.size() == 0)
            begin
                $error("result beat with none expected: kind %0d, format_byte 0x%02h", k, b);
                mismatches++;
                return;
            end
            e = answers_due.pop_front();
            kind_seen[e.kind]++;
            if (k !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, k);
                mismatches++;
            end
            if (b !== e.data)
            begin
                $error("format_byte: expected 0x%02h, got 0x%02h", e.data, b);
                mismatches++;
            end
            if (l !== e.last)
            begin
                $error("run_last: expected %0b, got %0b", e.last, l);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ----- sim/tb_top.sv -----
// Top of the testbench for fstab_format_field_extractor: drives table texts
// byte by byte, pops the result beats at random and checks them in order.
// Depends on fsfe_pkg, tb_fsfe_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import fsfe_pkg::*;
    import tb_fsfe_pkg::*;

    // Number of random text bytes to send after the directed part.
    localparam int TEXT_BEATS    = 1200;
    // Cycles with no beat moving on either side before the run is abandoned.
    localparam int STALL_LIMIT   = 2000;
    // Quiet cycles before a register write and at the end of the run. The
    // block queues its answer as soon as it takes a byte, so this is generous.
    localparam int SETTLE_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        push;
    logic        full;
    logic [7:0]  text_byte;
    logic        end_of_text;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [7:0]  format_byte;
    logic        run_last;

    format_scoreboard answer_book = new();

    // When set, neither side inserts idle cycles, so beats run back to back.
    bit         steady = 1'b0;
    int         beats_sent = 0;
    int         texts_sent = 0;
    int         settings_used = 0;
    int         idle_cycles = 0;
    // The name currently programmed, as the text generator sees it.
    int         len_now = 1;
    logic [7:0] name_now[16];
    logic [7:0] text_q[$];

    fstab_format_field_extractor DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .format_byte (format_byte),
        .run_last    (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: every accepted beat on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $error("no beat moved for %0d cycles", STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones. The result side stalls a little
    // more often so that the internal queue fills and full gets exercised.
    function automatic int idle_gap(input bit heavy);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < (heavy ? 40 : 60))
            return 0;
        if (r < 88)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Result side: raise pop after a random gap, hold it until one beat is
    // taken, then check that beat against the oldest prediction. Outputs are
    // read right after the edge, so they hold the values the edge sampled.
    initial
    begin : result_sink
        int gap;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = idle_gap(1'b1);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            answer_book.check_answer(kind, format_byte, run_last);
        end
    end

    // Offers one text byte and returns in the time step where it was taken.
    // The prediction is made here, so it is queued before its result can pop.
    task automatic send_beat(input logic [7:0] b, input logic eot);
        int gap;
        gap = idle_gap(1'b0);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (full)
            @(posedge clk);
        answer_book.predict_answer(b, eot);
        beats_sent++;
    endtask

    // Holds the input side until every predicted result beat has been popped.
    task automatic hold_until_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (answer_book.pending() != 0);
    endtask

    // Drains and then waits a little longer, since the last byte of a text
    // may be one that answers nothing while the block still works on it.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        answer_book.write_register(idx, v);
    endtask

    // Programs a fresh random name of the given length. Register bytes past
    // the length are filled with junk, which the block must not look at.
    task automatic configure_name(input int len);
        logic [127:0] packed_name;
        len_now = len;
        for (int i = 0; i < 16; i++)
        begin
            name_now[i] = token_byte();
            packed_name[8*i +: 8] = (i < len) ? name_now[i] : 8'($urandom_range(0, 255));
        end
        write_reg(CFG_NAME_LENGTH, 64'(len));
        write_reg(CFG_NAME_LOW, packed_name[63:0]);
        write_reg(CFG_NAME_HIGH, packed_name[127:64]);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Sends a whole text, flagging its final byte, and optionally pauses the
    // input side after one byte until all answers so far have come out.
    task automatic send_text(ref logic [7:0] t[$], input int pause_at);
        foreach (t[i])
        begin
            send_beat(t[i], i == t.size() - 1);
            if (i == pause_at)
                hold_until_drained();
        end
        texts_sent++;
    endtask

    // Whitespace other than newline; mostly plain spaces.
    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 9))
            0: return 8'd9;
            1: return 8'd11;
            2: return 8'd12;
            3: return 8'd13;
            default: return 8'd32;
        endcase
    endfunction

    // A byte that is part of a token: mostly printable, sometimes anything
    // that is not whitespace, including NUL and the upper half.
    function automatic logic [7:0] token_byte();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 9) < 7)
                c = 8'($urandom_range(33, 126));
            else
                c = 8'($urandom_range(0, 255));
        end
        while (c == 8'd32 || (c >= 8'd9 && c <= 8'd13));
        return c;
    endfunction

    task automatic add_blanks(ref logic [7:0] t[$], input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) t.push_back(blank_byte());
    endtask

    task automatic add_token(ref logic [7:0] t[$], input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) t.push_back(token_byte());
    endtask

    task automatic add_string(ref logic [7:0] t[$], input string s);
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
    endtask

    // Appends the name token. Variant 0 is the exact name, 1 drops its last
    // byte, 2 adds one byte, 3 changes one byte. For a length above the
    // maximum the token is that long, so the block must still refuse it.
    task automatic add_name(ref logic [7:0] t[$], input int variant);
        logic [7:0] w[$];
        logic [7:0] c;
        int         k;
        for (int i = 0; i < len_now && i < 16; i++)
            w.push_back(name_now[i]);
        for (int i = 16; i < len_now; i++)
            w.push_back(token_byte());
        if (w.size() == 0)
            w.push_back(token_byte());
        case (variant)
            1:
                if (w.size() > 1)
                    void'(w.pop_back());
                else
                    w.push_back(token_byte());
            2:
                w.push_back(token_byte());
            3:
            begin
                k = $urandom_range(0, w.size() - 1);
                do
                    c = token_byte();
                while (c == w[k]);
                w[k] = c;
            end
            default: ;
        endcase
        foreach (w[i])
            t.push_back(w[i]);
    endtask

    // One table line. Styles: 0 matching line with a format token, 1 matching
    // line with nothing after the name, 2 near miss on the name, 3 comment,
    // 4 blank, 5 device token only, 6 raw noise bytes.
    task automatic add_line(ref logic [7:0] t[$], input int style, input bit closed);
        int n;
        case (style)
            0, 1, 2:
            begin
                add_blanks(t, 0, 2);
                add_token(t, 1, 6);
                add_blanks(t, 1, 3);
                add_name(t, (style == 2) ? $urandom_range(1, 3) : 0);
                if (style == 1)
                    add_blanks(t, 0, 2);
                else
                begin
                    add_blanks(t, 1, 2);
                    add_token(t, 1, 8);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        add_blanks(t, 1, 2);
                        add_token(t, 1, 5);
                    end
                end
            end
            3:
            begin
                add_blanks(t, 0, 2);
                t.push_back(CHAR_HASH);
                add_token(t, 0, 5);
                add_blanks(t, 0, 1);
                add_token(t, 0, 4);
            end
            4:
                add_blanks(t, 0, 3);
            5:
            begin
                add_blanks(t, 0, 1);
                add_token(t, 1, 6);
                add_blanks(t, 0, 2);
            end
            default:
            begin
                n = $urandom_range(1, 12);
                repeat (n) t.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if (closed)
            t.push_back(CHAR_NEWLINE);
    endtask

    function automatic int pick_style();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return 0;
        if (r < 36) return 1;
        if (r < 56) return 2;
        if (r < 66) return 3;
        if (r < 73) return 4;
        if (r < 81) return 5;
        return 6;
    endfunction

    // Name lengths: mostly short, with the maximum, zero and the illegal
    // lengths above the maximum showing up now and then.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return $urandom_range(1, 4);
        if (r < 80) return $urandom_range(5, 15);
        if (r < 88) return 16;
        if (r < 94) return 0;
        return $urandom_range(17, 31);
    endfunction

    // A random text of one to six lines. The last line is often cut off by
    // the end of the text, which lands the end flag in every line phase.
    task automatic make_text(ref logic [7:0] t[$]);
        int lines;
        lines = $urandom_range(1, 6);
        for (int i = 0; i < lines; i++)
            add_line(t, pick_style(), (i < lines - 1) || ($urandom_range(0, 99) < 55));
        if (t.size() == 0)
            t.push_back(token_byte());
    endtask

    initial
    begin : stimulus
        int random_goal;
        int pause_at;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_NAME_LENGTH;
        cfg_data    = '0;
        push        = 1'b0;
        text_byte   = '0;
        end_of_text = 1'b0;
        foreach (name_now[i])
            name_now[i] = 8'h00;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset name (one NUL byte) first. A comment
        // line and a blank line are skipped, a name token longer than the
        // name misses, and the match has a format token that the end of the
        // text cuts off, so its only byte and found come out together.
        text_q.delete();
        add_string(text_q, "#x\n \nd ");
        text_q.push_back(8'h00);
        text_q.push_back(8'h00);
        add_string(text_q, " f\nd ");
        text_q.push_back(8'h00);
        add_string(text_q, " ");
        text_q.push_back(8'hFF);
        send_text(text_q, -1);

        // The name ends its line, so the answer is malformed. The input side
        // then waits for it, and the byte after the answer is ignored.
        text_q.delete();
        add_string(text_q, "d ");
        text_q.push_back(8'h00);
        add_string(text_q, "\nq");
        send_text(text_q, 3);

        // An empty name never matches.
        settle();
        configure_name(0);
        text_q.delete();
        add_string(text_q, "a b");
        send_text(text_q, -1);

        // A full sixteen byte name that the end of the text completes.
        settle();
        configure_name(16);
        text_q.delete();
        add_string(text_q, "d ");
        add_name(text_q, 0);
        send_text(text_q, -1);

        // Random part: mostly well-formed tables, with the name changed
        // between texts now and then, and the occasional pause.
        random_goal = beats_sent + TEXT_BEATS;
        while (beats_sent < random_goal)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                steady = 1'b0;
                settle();
                configure_name(pick_length());
            end
            steady = ($urandom_range(0, 4) == 0);
            text_q.delete();
            make_text(text_q);
            pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, text_q.size() - 1) : -1;
            send_text(text_q, pause_at);
        end

        settle();
        if (answer_book.pending() != 0)
            $error("%0d expected result beats never arrived", answer_book.pending());

        $display("Sent %0d text bytes in %0d texts under %0d name settings.",
                 beats_sent, texts_sent, settings_used);
        $display("Checked %0d format bytes, %0d found, %0d malformed, %0d not found.",
                 answer_book.kind_seen[KIND_BYTE], answer_book.kind_seen[KIND_FOUND],
                 answer_book.kind_seen[KIND_MALFORMED], answer_book.kind_seen[KIND_NOTFOUND]);
        if (answer_book.mismatches == 0 && answer_book.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/fsfe_pkg.sv
sv/fsfe_front.sv
sv/fsfe_queue.sv
sv/fsfe_back.sv
sv/fstab_format_field_extractor.sv
sim/tb_fsfe_pkg.sv
sim/tb_top.sv
